// ----- hdl/cpd_pkg.sv -----
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared types, constants and token tables for the connection persistence
// decider.
// ----------------------------------------------------------------------------
`default_nettype none

package cpd_pkg;

    // Field and register widths
    localparam int BYTE_BITS          = 8;
    localparam int LIMIT_BITS         = 16;
    localparam int COUNT_FIELD_BITS   = 16;
    localparam int CFG_INDEX_BITS     = 2;
    localparam int COUNT_BITS_DEFAULT = 16;

    // Token lengths and position counter widths
    localparam int CLOSE_LEN      = 5;
    localparam int KEEP_LEN       = 10;
    localparam int CLOSE_POS_BITS = 3;
    localparam int KEEP_POS_BITS  = 4;

    // Policy limits
    localparam logic [LIMIT_BITS-1:0] MAX_TIMEOUT = 16'd300;
    localparam logic [LIMIT_BITS-1:0] MAX_CAP     = 16'd4096;

    // Character codes
    localparam logic [BYTE_BITS-1:0] CHAR_COMMA   = 8'h2C;
    localparam logic [BYTE_BITS-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [BYTE_BITS-1:0] CHAR_TAB     = 8'h09;
    localparam logic [BYTE_BITS-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [BYTE_BITS-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [BYTE_BITS-1:0] CASE_OFFSET  = 8'h20;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_POLICY_ENABLED = 2'd0,
        CFG_IDLE_TIMEOUT   = 2'd1,
        CFG_CONNECTION_CAP = 2'd2
    } cfg_index_t;

    // Header scan result handed to the decision logic
    typedef struct packed {
        logic close_found;
        logic keep_found;
    } scan_result_t;

    // "close", lower case
    function automatic logic [BYTE_BITS-1:0] close_char(
        input logic [CLOSE_POS_BITS-1:0] pos
    );
        logic [BYTE_BITS-1:0] c;
        unique case (pos)
            3'd0:    c = 8'h63;
            3'd1:    c = 8'h6C;
            3'd2:    c = 8'h6F;
            3'd3:    c = 8'h73;
            3'd4:    c = 8'h65;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "keep-alive", lower case
    function automatic logic [BYTE_BITS-1:0] keep_char(
        input logic [KEEP_POS_BITS-1:0] pos
    );
        logic [BYTE_BITS-1:0] c;
        unique case (pos)
            4'd0:    c = 8'h6B;
            4'd1:    c = 8'h65;
            4'd2:    c = 8'h65;
            4'd3:    c = 8'h70;
            4'd4:    c = 8'h2D;
            4'd5:    c = 8'h61;
            4'd6:    c = 8'h6C;
            4'd7:    c = 8'h69;
            4'd8:    c = 8'h76;
            4'd9:    c = 8'h65;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/cpd_scan.sv -----
// ----------------------------------------------------------------------------
// cpd_scan
// Element splitter and token matcher: tracks the current comma-separated
// element and whether close or keep-alive has been found in the header.
// ----------------------------------------------------------------------------
`default_nettype none

module cpd_scan (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           advance,
    input  wire logic [cpd_pkg::BYTE_BITS-1:0]  header_byte,
    input  wire logic                           byte_present,
    input  wire logic                           last_byte,
    output cpd_pkg::scan_result_t               result
);
    import cpd_pkg::*;

    logic [CLOSE_POS_BITS-1:0] close_pos_reg, close_pos_next;
    logic [KEEP_POS_BITS-1:0]  keep_pos_reg,  keep_pos_next;
    logic close_live_reg,  close_live_next;
    logic keep_live_reg,   keep_live_next;
    logic has_text_reg,    has_text_next;
    logic trail_reg,       trail_next;
    logic close_found_reg, close_found_next;
    logic keep_found_reg,  keep_found_next;
    logic [BYTE_BITS-1:0] low_byte;

    assign low_byte = (header_byte >= CHAR_UPPER_A && header_byte <= CHAR_UPPER_Z)
                    ? header_byte + CASE_OFFSET : header_byte;

    always_comb begin
        close_pos_next   = close_pos_reg;
        keep_pos_next    = keep_pos_reg;
        close_live_next  = close_live_reg;
        keep_live_next   = keep_live_reg;
        has_text_next    = has_text_reg;
        trail_next       = trail_reg;
        close_found_next = close_found_reg;
        keep_found_next  = keep_found_reg;

        if (byte_present) begin
            case (header_byte) inside
                CHAR_COMMA: begin
                    // close the element and start a fresh one
                    close_found_next = close_found_reg |
                        (close_live_reg && close_pos_reg == CLOSE_POS_BITS'(CLOSE_LEN));
                    keep_found_next  = keep_found_reg |
                        (keep_live_reg && keep_pos_reg == KEEP_POS_BITS'(KEEP_LEN));
                    close_pos_next  = '0;
                    keep_pos_next   = '0;
                    close_live_next = 1'b1;
                    keep_live_next  = 1'b1;
                    has_text_next   = 1'b0;
                    trail_next      = 1'b0;
                end
                CHAR_SPACE, CHAR_TAB: begin
                    if (has_text_reg) begin
                        trail_next = 1'b1;
                    end
                end
                default: begin
                    // whitespace after text, followed by more text, spoils both tokens
                    if (trail_reg) begin
                        close_live_next = 1'b0;
                        keep_live_next  = 1'b0;
                        trail_next      = 1'b0;
                    end
                    has_text_next = 1'b1;
                    if (close_live_next) begin
                        if (close_pos_reg < CLOSE_POS_BITS'(CLOSE_LEN) &&
                            low_byte == close_char(close_pos_reg)) begin
                            close_pos_next = close_pos_reg + 3'd1;
                        end else begin
                            close_live_next = 1'b0;
                        end
                    end
                    if (keep_live_next) begin
                        if (keep_pos_reg < KEEP_POS_BITS'(KEEP_LEN) &&
                            low_byte == keep_char(keep_pos_reg)) begin
                            keep_pos_next = keep_pos_reg + 4'd1;
                        end else begin
                            keep_live_next = 1'b0;
                        end
                    end
                end
            endcase
        end

        // flags as they stand once the open element is closed
        result.close_found = close_found_next |
            (close_live_next && close_pos_next == CLOSE_POS_BITS'(CLOSE_LEN));
        result.keep_found  = keep_found_next |
            (keep_live_next && keep_pos_next == KEEP_POS_BITS'(KEEP_LEN));

        if (last_byte) begin
            close_pos_next   = '0;
            keep_pos_next    = '0;
            close_live_next  = 1'b1;
            keep_live_next   = 1'b1;
            has_text_next    = 1'b0;
            trail_next       = 1'b0;
            close_found_next = 1'b0;
            keep_found_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            close_pos_reg   <= '0;
            keep_pos_reg    <= '0;
            close_live_reg  <= 1'b1;
            keep_live_reg   <= 1'b1;
            has_text_reg    <= 1'b0;
            trail_reg       <= 1'b0;
            close_found_reg <= 1'b0;
            keep_found_reg  <= 1'b0;
        end else if (advance) begin
            close_pos_reg   <= close_pos_next;
            keep_pos_reg    <= keep_pos_next;
            close_live_reg  <= close_live_next;
            keep_live_reg   <= keep_live_next;
            has_text_reg    <= has_text_next;
            trail_reg       <= trail_next;
            close_found_reg <= close_found_next;
            keep_found_reg  <= keep_found_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/connection_persistence_decider.sv -----
// ----------------------------------------------------------------------------
// connection_persistence_decider
// Streams Connection header bytes and decides whether to keep the
// connection open.
// ----------------------------------------------------------------------------
// The block takes one header byte per item, one item per clock, and gives a
// single decision item for each header, on the item marked last. Every item
// first lands in an input register; when it moves on, the scanner updates
// its element state and, for a last item, the decision is loaded into the
// result register. The sustained rate is one item per cycle; the input side
// only stalls when a last item finds a decision still waiting on the result
// side. Elements are split on commas, trimmed of space and tab, and compared
// whole and case-insensitively with close and keep-alive. HTTP/1.1 keeps
// unless close was seen; HTTP/1.0 keeps only if keep-alive was seen; the
// policy (enable, timeout 1..300, cap 1..4096) and parked count below the
// cap gate the result. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module connection_persistence_decider #(
    parameter int COUNT_BITS = cpd_pkg::COUNT_BITS_DEFAULT
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // configuration write channel
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [cpd_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic [cpd_pkg::LIMIT_BITS-1:0]         cfg_data,
    // header byte items
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic [cpd_pkg::BYTE_BITS-1:0]          s_header_byte,
    input  wire logic                                   s_byte_present,
    input  wire logic                                   s_last_byte,
    input  wire logic                                   s_version_is_1_0,
    input  wire logic [cpd_pkg::COUNT_FIELD_BITS-1:0]   s_parked_count,
    // decision items
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic                                        m_keep_open,
    output logic                                        m_close_seen,
    output logic                                        m_keep_alive_seen,
    output logic                                        m_policy_ok
);
    import cpd_pkg::*;

    // the cap compare works on the narrower of the count width and the field
    localparam int CMP_BITS = (COUNT_BITS < COUNT_FIELD_BITS) ? COUNT_BITS
                                                              : COUNT_FIELD_BITS;

    // configuration registers
    logic                  policy_enabled_reg;
    logic [LIMIT_BITS-1:0] idle_timeout_reg;
    logic [LIMIT_BITS-1:0] connection_cap_reg;

    // input register
    logic                        in_valid_reg;
    logic [BYTE_BITS-1:0]        in_byte_reg;
    logic                        in_present_reg;
    logic                        in_last_reg;
    logic                        in_v10_reg;
    logic [COUNT_FIELD_BITS-1:0] in_parked_reg;

    // result register
    logic m_valid_reg;
    logic keep_open_reg, close_seen_reg, keep_seen_reg, policy_ok_reg;

    logic         out_free;
    logic         advance;
    logic         s_take;
    scan_result_t scan;
    logic         requested;
    logic         policy_ok;
    logic         below_cap;
    logic         keep_open;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_enabled_reg <= 1'b0;
            idle_timeout_reg   <= '0;
            connection_cap_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_POLICY_ENABLED: policy_enabled_reg <= cfg_data[0];
                CFG_IDLE_TIMEOUT:   idle_timeout_reg   <= cfg_data;
                CFG_CONNECTION_CAP: connection_cap_reg <= cfg_data;
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    // advance a non-last item always; a last item needs room for its result
    assign out_free = !m_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready  = !in_valid_reg || advance;
    assign s_take   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_byte_reg    <= s_header_byte;
            in_present_reg <= s_byte_present;
            in_last_reg    <= s_last_byte;
            in_v10_reg     <= s_version_is_1_0;
            in_parked_reg  <= s_parked_count;
        end
    end

    cpd_scan u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .header_byte  (in_byte_reg),
        .byte_present (in_present_reg),
        .last_byte    (in_last_reg),
        .result       (scan)
    );

    // decision
    assign requested = in_v10_reg ? scan.keep_found : !scan.close_found;
    assign policy_ok = policy_enabled_reg &&
                       idle_timeout_reg >= LIMIT_BITS'(1) &&
                       idle_timeout_reg <= MAX_TIMEOUT &&
                       connection_cap_reg >= LIMIT_BITS'(1) &&
                       connection_cap_reg <= MAX_CAP;
    assign below_cap = in_parked_reg[CMP_BITS-1:0] < connection_cap_reg[CMP_BITS-1:0];
    assign keep_open = requested && policy_ok && below_cap;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            keep_open_reg  <= keep_open;
            close_seen_reg <= scan.close_found;
            keep_seen_reg  <= scan.keep_found;
            policy_ok_reg  <= policy_ok;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_keep_open       = keep_open_reg;
    assign m_close_seen      = close_seen_reg;
    assign m_keep_alive_seen = keep_seen_reg;
    assign m_policy_ok       = policy_ok_reg;

endmodule

`default_nettype wire
